[hdl/ffha_pkg.sv]
package ffha_pkg;

  localparam int ARENA_BYTES  = 16384;
  localparam int HEADER_BYTES = 12;
  localparam int MAX_SEGMENTS = 64;

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int OFS_W  = 14;
  localparam int SIZE_W = 15;
  localparam int ENT_W  = OFS_W + SIZE_W + 1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [OFS_W-1:0]  ofs;
    logic [SIZE_W-1:0] size;
    logic              used;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_SHUP_WR,
    S_FREE_NB,
    S_SHDN,
    S_SHDN_WR,
    S_DONE
  } state_t;

endpackage

[hdl/ffha_ram.sv]
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/first_fit_heap_allocator_top.sv]
// Channel  Dir  tdata fields (lsb first)             tuser
// s_axis   in   size_bytes[14:0], address[29:15]     kind
// m_axis   out  status[1:0], payload_offset[16:2]    -
//
// One request at a time. The scan visits the segment table entry by entry, reading each
// entry and then checking it; a split then moves the entries above it up at one per cycle, and a free
// that merges moves them down at one per cycle after one extra read.
// The table has one read port and one write port; the time to a result grows with the entries
// visited and moved, and a full table of 64 segments sets the worst case.
// Reset leaves one free segment covering the arena. It is written while init_done is
// still low, and s_axis_tready stays low until init_done is set.
// A result waits in its output register; tready stays low until it is taken.
module first_fit_heap_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // size_bytes[14:0], address[29:15]
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status[1:0], payload_offset[16:2]
);

  localparam int IW = ffha_pkg::IDX_W;
  localparam int CW = ffha_pkg::CNT_W;
  localparam int SW = ffha_pkg::SIZE_W;
  localparam int OW = ffha_pkg::OFS_W;

  ffha_pkg::state_t state, state_next;

  logic          init_done;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;        // current position in the table
  logic          kind;
  logic [SW-1:0] want;
  logic [SW-1:0] addr;
  ffha_pkg::entry_t cur;     // segment being released
  ffha_pkg::entry_t prev;    // entry before the current scan position
  ffha_pkg::entry_t carry;   // entry being moved up during a split
  logic [1:0]    status;
  logic [SW-1:0] pay;
  logic          out_valid;
  logic [CW-1:0] pos;        // index of the segment being released
  logic [1:0]    gap;        // entries removed by a merge

  logic          we;
  logic [IW-1:0] waddr, raddr;
  ffha_pkg::entry_t wdata, rdata;

  ffha_ram #(.WIDTH(ffha_pkg::ENT_W), .DEPTH(ffha_pkg::MAX_SEGMENTS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic          in_take;
  logic [SW:0]   want_h;
  logic [SW:0]   pay_calc;
  logic [SW:0]   rest_ofs;
  logic          fit, exact, split, full, hit;
  logic          nx, mp;
  logic [SW:0]   merged_size;
  logic [CW-1:0] merged_pos;
  logic [1:0]    merged_gap;
  logic [CW-1:0] count_left;
  logic [CW-1:0] next1;
  logic [CW-1:0] rd_dn;
  logic [CW-1:0] rd_dn_next;
  ffha_pkg::entry_t grant, rest, merged;

  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign want_h   = {1'b0, want} + (SW+1)'(ffha_pkg::HEADER_BYTES);
  assign pay_calc = {2'b0, rdata.ofs} + (SW+1)'(ffha_pkg::HEADER_BYTES);
  assign rest_ofs = pay_calc + {1'b0, want};

  assign fit   = !rdata.used && (rdata.size >= want);
  assign exact = rdata.size == want;
  assign split = {1'b0, rdata.size} > want_h;
  assign full  = count >= CW'(ffha_pkg::MAX_SEGMENTS);
  assign hit   = pay_calc == {1'b0, addr};

  assign grant = '{ofs: rdata.ofs, size: want, used: 1'b1};
  assign rest  = '{ofs: rest_ofs[OW-1:0], size: rdata.size - want_h[SW-1:0], used: 1'b0};

  // While merging, rdata holds the entry after the released segment.
  assign nx = (pos + CW'(1) < count) && !rdata.used;
  assign mp = (pos != '0) && !prev.used;
  assign merged_size = {1'b0, cur.size}
                     + (nx ? ({1'b0, rdata.size} + (SW+1)'(ffha_pkg::HEADER_BYTES)) : '0)
                     + (mp ? ({1'b0, prev.size} + (SW+1)'(ffha_pkg::HEADER_BYTES)) : '0);
  assign merged_gap = {1'b0, nx} + {1'b0, mp};
  assign merged_pos = mp ? pos - CW'(1) : pos;
  assign count_left = count - CW'(merged_gap);
  assign merged = '{ofs: (mp ? prev.ofs : cur.ofs), size: merged_size[SW-1:0], used: 1'b0};

  assign next1      = idx + CW'(1);
  assign rd_dn      = idx + CW'(gap);
  assign rd_dn_next = idx + CW'(gap) + CW'(1);

  assign s_axis_tready = (state == ffha_pkg::S_IDLE) && init_done && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, pay, status};

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ffha_pkg::S_IDLE: if (in_take) state_next = ffha_pkg::S_SCAN;
      ffha_pkg::S_SCAN: state_next = (idx < count) ? ffha_pkg::S_SCAN_CHK : ffha_pkg::S_DONE;
      ffha_pkg::S_SCAN_CHK: begin
        if (kind == ffha_pkg::KIND_ALLOC) begin
          if (fit) begin
            state_next = (!exact && split && !full) ? ffha_pkg::S_SHUP_WR : ffha_pkg::S_DONE;
          end else begin
            state_next = ffha_pkg::S_SCAN;
          end
        end else begin
          if (hit) begin
            state_next = rdata.used ? ffha_pkg::S_FREE_NB : ffha_pkg::S_DONE;
          end else begin
            state_next = ffha_pkg::S_SCAN;
          end
        end
      end
      ffha_pkg::S_SHUP_WR: if (idx == count) state_next = ffha_pkg::S_DONE;
      ffha_pkg::S_FREE_NB: begin
        if ((merged_gap != 2'd0) && (merged_pos + CW'(1) < count_left)) begin
          state_next = ffha_pkg::S_SHDN;
        end else begin
          state_next = ffha_pkg::S_DONE;
        end
      end
      ffha_pkg::S_SHDN:    state_next = ffha_pkg::S_SHDN_WR;
      ffha_pkg::S_SHDN_WR: if (next1 >= count) state_next = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE:    state_next = ffha_pkg::S_IDLE;
      default:             state_next = ffha_pkg::S_IDLE;
    endcase
  end

  // Table port control. Reads lead writes by one entry in a split, by gap plus one in a merge.
  always_comb begin
    we    = 1'b0;
    waddr = idx[IW-1:0];
    wdata = carry;
    raddr = idx[IW-1:0];
    unique case (state)
      ffha_pkg::S_IDLE: begin
        if (!init_done) begin
          we = 1'b1;
          waddr = '0;
          wdata.ofs = '0;
          wdata.size = SW'(ffha_pkg::ARENA_BYTES - ffha_pkg::HEADER_BYTES);
          wdata.used = 1'b0;
        end
      end
      ffha_pkg::S_SCAN: ;
      ffha_pkg::S_SCAN_CHK: begin
        raddr = next1[IW-1:0];
        if (kind == ffha_pkg::KIND_ALLOC && fit && (exact || (split && !full))) begin
          we = 1'b1;
          wdata = grant;
        end
      end
      ffha_pkg::S_SHUP_WR: begin
        we = 1'b1;
        raddr = next1[IW-1:0];
      end
      ffha_pkg::S_FREE_NB: begin
        we = 1'b1;
        waddr = merged_pos[IW-1:0];
        wdata = merged;
      end
      ffha_pkg::S_SHDN: raddr = rd_dn[IW-1:0];
      ffha_pkg::S_SHDN_WR: begin
        we = 1'b1;
        wdata = rdata;
        raddr = rd_dn_next[IW-1:0];
      end
      ffha_pkg::S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffha_pkg::S_IDLE;
      init_done <= 1'b0;
      count     <= CW'(1);
      out_valid <= 1'b0;
      idx       <= '0;
      pos       <= '0;
      gap       <= '0;
    end else begin
      state     <= state_next;
      init_done <= 1'b1;
      if (state == ffha_pkg::S_DONE) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
      unique case (state)
        ffha_pkg::S_IDLE: if (in_take) begin
          kind <= s_axis_tuser;
          want <= s_axis_tdata[14:0];
          addr <= s_axis_tdata[29:15];
          idx  <= '0;
          status <= (s_axis_tuser == ffha_pkg::KIND_FREE) ? ffha_pkg::ST_BAD_FREE
                                                          : ffha_pkg::ST_NO_SPACE;
          pay  <= '0;
        end
        ffha_pkg::S_SCAN: ;
        ffha_pkg::S_SCAN_CHK: begin
          if (kind == ffha_pkg::KIND_ALLOC) begin
            if (fit) begin
              // The first free segment that is large enough ends the scan.
              if (exact) begin
                status <= ffha_pkg::ST_OK;
                pay <= pay_calc[SW-1:0];
              end else if (split) begin
                if (full) begin
                  status <= ffha_pkg::ST_FULL;
                end else begin
                  status <= ffha_pkg::ST_OK;
                  pay <= pay_calc[SW-1:0];
                  carry <= rest;
                  idx <= next1;
                end
              end
            end else begin
              idx <= next1;
            end
          end else begin
            if (hit) begin
              if (rdata.used) begin
                cur <= rdata;
                pos <= idx;
              end
            end else begin
              prev <= rdata;
              idx <= next1;
            end
          end
        end
        // Write carry at idx and pick up the entry that it displaces.
        ffha_pkg::S_SHUP_WR: begin
          carry <= rdata;
          if (idx == count) count <= count + CW'(1);
          else idx <= next1;
        end
        ffha_pkg::S_FREE_NB: begin
          status <= ffha_pkg::ST_OK;
          count <= count_left;
          gap <= merged_gap;
          idx <= merged_pos + CW'(1);
        end
        ffha_pkg::S_SHDN: ;
        ffha_pkg::S_SHDN_WR: if (next1 < count) idx <= next1;
        ffha_pkg::S_DONE: ;
        default: ;
      endcase
    end
  end

endmodule
